// File: src/rutk_pkg.sv
package rutk_pkg;

  localparam int MaxRecords = 64;
  localparam int IdxW = $clog2(MaxRecords);
  localparam int CntW = $clog2(MaxRecords + 1);
  localparam int LimW = 7;
  localparam int RankW = 51;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_EXCL,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  localparam logic CFG_CAND_LIMIT = 1'b0;
  localparam logic CFG_QRY_LIMIT = 1'b1;

  typedef struct packed {
    logic store;
    logic scan_start;
    logic scan_step;
    logic excl_start;
    logic excl_step;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic excl_done;
    logic more;
  } status_t;

  function automatic logic [RankW-1:0] pack_rank(logic tier, logic [31:0] cost,
                                                 logic [15:0] cyc, logic nq, logic inv,
                                                 logic tf);
    logic [1:0] prio;
    begin
      if (nq) prio = 2'd0;
      else if (inv) prio = 2'd1;
      else if (tf) prio = 2'd2;
      else prio = 2'd3;
      pack_rank = {tier, cost, cyc, prio};
    end
  endfunction

endpackage

// File: src/rutk_datapath.sv
module rutk_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  rutk_pkg::cmd_t                 cmd,
  input  logic [rutk_pkg::RankW-1:0]     in_rank,
  input  logic [63:0]                    in_time,
  input  logic [63:0]                    in_key,
  output rutk_pkg::status_t              status,
  output logic [rutk_pkg::IdxW-1:0]      best_index
);

  localparam int N = rutk_pkg::MaxRecords;
  localparam int IW = rutk_pkg::IdxW;
  localparam int CW = rutk_pkg::CntW;

  logic [rutk_pkg::RankW-1:0] rank_mem [N];
  logic [63:0] time_mem [N];
  logic [63:0] key_mem [N];
  logic [N-1:0] excluded;
  logic [CW-1:0] record_count;
  logic [CW-1:0] ptr;
  logic rd_valid;
  logic [IW-1:0] rd_index;
  logic [rutk_pkg::RankW-1:0] rd_rank;
  logic [63:0] rd_time;
  logic [63:0] rd_key;
  logic found;
  logic more;
  logic [IW-1:0] best;
  logic [rutk_pkg::RankW-1:0] best_rank;
  logic [63:0] best_time;
  logic [63:0] best_key;
  logic better;

  always_ff @(posedge clk) begin
    if (cmd.store && record_count < CW'(N)) begin
      rank_mem[record_count[IW-1:0]] <= in_rank;
      time_mem[record_count[IW-1:0]] <= in_time;
      key_mem[record_count[IW-1:0]] <= in_key;
    end
    rd_rank <= rank_mem[ptr[IW-1:0]];
    rd_time <= time_mem[ptr[IW-1:0]];
    rd_key <= key_mem[ptr[IW-1:0]];
  end

  always_comb begin
    if (rd_rank[50] != best_rank[50]) better = rd_rank[50];
    else if (rd_rank[49:18] != best_rank[49:18]) better = rd_rank[49:18] < best_rank[49:18];
    else if (rd_rank[17:2] != best_rank[17:2]) better = rd_rank[17:2] > best_rank[17:2];
    else if (rd_time != best_time) better = rd_time < best_time;
    else if (rd_rank[1:0] != best_rank[1:0]) better = rd_rank[1:0] < best_rank[1:0];
    else better = rd_key < best_key;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      record_count <= '0;
      excluded <= '0;
      ptr <= '0;
      rd_valid <= 1'b0;
      found <= 1'b0;
      more <= 1'b0;
    end else begin
      if (cmd.store && record_count < CW'(N)) begin
        record_count <= record_count + 1'b1;
      end
      if (cmd.scan_start || cmd.excl_start) begin
        ptr <= '0;
        rd_valid <= 1'b0;
        if (cmd.scan_start) found <= 1'b0;
        if (cmd.excl_start) more <= 1'b0;
      end else if (cmd.scan_step || cmd.excl_step) begin
        rd_valid <= ptr < record_count;
        rd_index <= ptr[IW-1:0];
        if (ptr < record_count) ptr <= ptr + 1'b1;
        if (rd_valid && cmd.scan_step && !excluded[rd_index] && (!found || better)) begin
          found <= 1'b1;
          best <= rd_index;
          best_rank <= rd_rank;
          best_time <= rd_time;
          best_key <= rd_key;
        end
        if (rd_valid && cmd.excl_step && rd_key == best_key) excluded[rd_index] <= 1'b1;
        if (rd_valid && cmd.excl_step && !excluded[rd_index] && rd_key != best_key) begin
          more <= 1'b1;
        end
      end
    end
  end

  assign status.scan_done = !rd_valid && ptr == record_count;
  assign status.found = found;
  assign status.excl_done = !rd_valid && ptr == record_count;
  assign status.more = more;
  assign best_index = best;

endmodule

// File: src/rutk_controller.sv
module rutk_controller (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_fire,
  input  logic                      in_last,
  input  logic [rutk_pkg::LimW-1:0] limit,
  input  rutk_pkg::status_t         status,
  input  logic                      out_taken,
  output rutk_pkg::cmd_t            cmd,
  output logic                      in_ready,
  output logic                      out_pending,
  output logic                      out_valid_flag,
  output logic                      out_last_flag
);

  rutk_pkg::state_t state, state_next;
  logic [rutk_pkg::LimW-1:0] emitted, emitted_next;
  logic started, started_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rutk_pkg::ST_LOAD;
      emitted <= '0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      emitted <= emitted_next;
      started <= started_next;
    end
  end

  always_comb begin
    state_next = state;
    emitted_next = emitted;
    started_next = 1'b0;
    cmd = '0;
    in_ready = 1'b0;
    out_pending = 1'b0;
    out_valid_flag = 1'b1;
    out_last_flag = 1'b0;
    unique case (state)
      rutk_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        cmd.store = in_fire;
        if (in_fire && in_last) begin
          emitted_next = '0;
          if (limit == '0) begin
            state_next = rutk_pkg::ST_EMPTY;
          end else begin
            state_next = rutk_pkg::ST_SCAN;
            started_next = 1'b1;
          end
        end
      end
      rutk_pkg::ST_SCAN: begin
        if (started) begin
          cmd.scan_start = 1'b1;
        end else if (status.scan_done) begin
          if (!status.found) begin
            state_next = emitted == '0 ? rutk_pkg::ST_EMPTY : rutk_pkg::ST_LOAD;
            cmd.clear = emitted != '0;
          end else begin
            state_next = rutk_pkg::ST_EXCL;
            cmd.excl_start = 1'b1;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      rutk_pkg::ST_EXCL: begin
        if (status.excl_done && !started) begin
          state_next = rutk_pkg::ST_EMIT;
          emitted_next = emitted + 1'b1;
        end else begin
          cmd.excl_step = 1'b1;
        end
      end
      rutk_pkg::ST_EMIT: begin
        out_pending = 1'b1;
        out_last_flag = emitted >= limit || !status.more;
        if (out_taken) begin
          if (emitted >= limit || !status.more) begin
            state_next = rutk_pkg::ST_LOAD;
            cmd.clear = 1'b1;
          end else begin
            state_next = rutk_pkg::ST_SCAN;
            started_next = 1'b1;
          end
        end
      end
      rutk_pkg::ST_EMPTY: begin
        out_pending = 1'b1;
        out_valid_flag = 1'b0;
        out_last_flag = 1'b1;
        if (out_taken) begin
          state_next = rutk_pkg::ST_LOAD;
          cmd.clear = 1'b1;
        end
      end
      default: state_next = rutk_pkg::ST_LOAD;
    endcase
  end

endmodule

// File: src/ranked_unique_topk_selector_unit.sv
// Ranked unique top-k selector.
// Records enter on the s_axis channel, one word per cycle while loading, numbered by arrival.
// s_axis_tlast marks the last record of a batch and starts the selection run.
// Results leave on m_axis: the arrival index of each chosen record, best first,
// with m_axis_tuser as index_valid and m_axis_tlast on the final result.
// Records sharing a key with a chosen record are skipped thereafter.
// Each result takes one pass over the record memory to find the best entry and
// one pass to exclude its key, each reading one entry per cycle from the memory
// read port. The run stops at the smaller of the two limits on the cfg channel,
// or earlier once every remaining record shares a key with a chosen one.
// A zero limit or an empty batch gives one result with index_valid low.
// Input is not accepted during a run. When m_axis_tready is low the result
// word holds until taken. Reset empties the batch and sets both limits to 64.
// The cfg channel is always ready and should be written only while idle.
module ranked_unique_topk_selector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tier_one_unqueried, cost_bound, cycles_unqueried, last_query_time,
  // never-queried flag, invalidated flag, transient-failure flag, record_key,
  // zero fill
  input  logic [183:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // record_index, zero fill
  output logic [7:0]  m_axis_tdata,
  // index_valid
  output logic        m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [rutk_pkg::LimW-1:0] cand_limit;
  logic [rutk_pkg::LimW-1:0] qry_limit;
  logic [rutk_pkg::LimW-1:0] limit;
  rutk_pkg::cmd_t cmd;
  rutk_pkg::status_t status;
  logic [rutk_pkg::IdxW-1:0] best_index;
  logic in_fire, out_taken, out_pending, vflag, lflag;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_limit <= 7'd64;
      qry_limit <= 7'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index[0])
        rutk_pkg::CFG_CAND_LIMIT: cand_limit <= cfg_data;
        rutk_pkg::CFG_QRY_LIMIT: qry_limit <= cfg_data;
        default: ;
      endcase
    end
  end
  assign limit = cand_limit < qry_limit ? cand_limit : qry_limit;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_taken = m_axis_tvalid && m_axis_tready;

  rutk_controller u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_last(s_axis_tlast), .limit(limit),
    .status(status), .out_taken(out_taken), .cmd(cmd), .in_ready(s_axis_tready),
    .out_pending(out_pending), .out_valid_flag(vflag), .out_last_flag(lflag)
  );

  rutk_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .in_rank(rutk_pkg::pack_rank(s_axis_tdata[0], s_axis_tdata[32:1],
                                 s_axis_tdata[48:33], s_axis_tdata[113],
                                 s_axis_tdata[114], s_axis_tdata[115])),
    .in_time(s_axis_tdata[112:49]), .in_key(s_axis_tdata[179:116]),
    .status(status), .best_index(best_index)
  );

  assign m_axis_tvalid = out_pending;
  assign m_axis_tdata = vflag ? {2'b00, best_index} : 8'd0;
  assign m_axis_tuser = vflag;
  assign m_axis_tlast = lflag;

  a_no_in_during_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready during output");
  a_invalid_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast) else $error("invalid not last");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result dropped");

endmodule
